>>> hw/rtl/oldf_pkg.sv
// Shared types for the opcode/length packet deframer.
package oldf_pkg;

    localparam int BYTE_W = 8;

    // Kind of an input word.
    localparam logic FUNC_STREAM = 1'b0;
    localparam logic FUNC_TABLE  = 1'b1;

    // One length table entry: variable-length mark and fixed payload length.
    typedef struct packed {
        logic              variable;
        logic [BYTE_W-1:0] len;
    } entry_t;

endpackage

>>> hw/rtl/oldf_len_table.sv
// Per-opcode length table: synchronous memory with per-entry valid bits.
module oldf_len_table #(
    parameter int TABLE_ENTRIES = 256
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_en,
    input  logic [7:0]           wr_addr,
    input  oldf_pkg::entry_t     wr_entry,
    input  logic                 rd_en,
    input  logic [7:0]           rd_addr,
    output oldf_pkg::entry_t     rd_entry
);

    localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam logic [8:0] DEPTH = 9'(TABLE_ENTRIES);

    oldf_pkg::entry_t mem [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] vld_reg;
    oldf_pkg::entry_t rd_data_reg;
    logic rd_hit_reg;

    logic wr_in_range;
    logic rd_in_range;

    assign wr_in_range = {1'b0, wr_addr} < DEPTH;
    assign rd_in_range = {1'b0, rd_addr} < DEPTH;

    always_ff @(posedge clk)
    begin
        if (wr_en && wr_in_range)
        begin
            mem[wr_addr[AW-1:0]] <= wr_entry;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr[AW-1:0]];
        end
    end

    // Entries never written since reset read as fixed length zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_hit_reg <= 1'b0;
        end
        else
        begin
            if (wr_en && wr_in_range)
            begin
                vld_reg[wr_addr[AW-1:0]] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_hit_reg <= rd_in_range && vld_reg[rd_addr[AW-1:0]];
            end
        end
    end

    assign rd_entry = rd_hit_reg ? rd_data_reg : '0;

endmodule

>>> hw/rtl/oldf_parser.sv
// Packet parser stage: phase tracking, result formation and output register.
module oldf_parser (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             take,
    input  logic [7:0]       byte_in,
    input  oldf_pkg::entry_t entry,
    input  logic             out_stall,
    output logic             up_stall,
    output logic             out_valid,
    output logic [7:0]       opcode,
    output logic [7:0]       payload_byte,
    output logic             payload_valid,
    output logic [7:0]       byte_index,
    output logic [7:0]       packet_length,
    output logic             last
);

    localparam logic [1:0] PH_OPCODE  = 2'd0;
    localparam logic [1:0] PH_LENGTH  = 2'd1;
    localparam logic [1:0] PH_PAYLOAD = 2'd2;

    logic [1:0] phase_reg, phase_next;
    logic [7:0] cur_op_reg, cur_op_next;
    logic [7:0] exp_len_reg, exp_len_next;
    logic [7:0] seen_reg, seen_next;
    logic       s1_valid_reg, s1_valid_next;
    logic [7:0] s1_byte_reg;
    logic       out_valid_reg, out_valid_next;

    logic [7:0] o_op_reg, o_op_next;
    logic [7:0] o_byte_reg, o_byte_next;
    logic       o_pv_reg, o_pv_next;
    logic [7:0] o_idx_reg, o_idx_next;
    logic [7:0] o_len_reg, o_len_next;
    logic       o_last_reg, o_last_next;

    logic go;
    logic emit;
    logic is_last;

    assign go       = !out_valid_reg || !out_stall;
    assign up_stall = s1_valid_reg && !go;
    assign is_last  = ({1'b0, seen_reg} + 9'd1) >= {1'b0, exp_len_reg};

    always_comb
    begin
        phase_next   = phase_reg;
        cur_op_next  = cur_op_reg;
        exp_len_next = exp_len_reg;
        seen_next    = seen_reg;
        emit         = 1'b0;
        o_op_next    = cur_op_reg;
        o_byte_next  = 8'd0;
        o_pv_next    = 1'b0;
        o_idx_next   = 8'd0;
        o_len_next   = 8'd0;
        o_last_next  = 1'b1;
        if (s1_valid_reg && go)
        begin
            unique case (phase_reg)
                PH_LENGTH:
                begin
                    seen_next = 8'd0;
                    if (s1_byte_reg == 8'd0)
                    begin
                        emit         = 1'b1;
                        phase_next   = PH_OPCODE;
                        exp_len_next = 8'd0;
                    end
                    else
                    begin
                        phase_next   = PH_PAYLOAD;
                        exp_len_next = s1_byte_reg;
                    end
                end
                PH_PAYLOAD:
                begin
                    emit        = 1'b1;
                    o_byte_next = s1_byte_reg;
                    o_pv_next   = 1'b1;
                    o_idx_next  = seen_reg;
                    o_len_next  = exp_len_reg;
                    o_last_next = is_last;
                    if (is_last)
                    begin
                        phase_next = PH_OPCODE;
                        seen_next  = 8'd0;
                    end
                    else
                    begin
                        seen_next = seen_reg + 8'd1;
                    end
                end
                default:
                begin
                    // Opcode byte; the unused phase code behaves the same way.
                    cur_op_next = s1_byte_reg;
                    o_op_next   = s1_byte_reg;
                    seen_next   = 8'd0;
                    if (entry.variable)
                    begin
                        phase_next   = PH_LENGTH;
                        exp_len_next = 8'd0;
                    end
                    else if (entry.len == 8'd0)
                    begin
                        emit         = 1'b1;
                        phase_next   = PH_OPCODE;
                        exp_len_next = 8'd0;
                    end
                    else
                    begin
                        phase_next   = PH_PAYLOAD;
                        exp_len_next = entry.len;
                    end
                end
            endcase
        end
    end

    always_comb
    begin
        if (take)
        begin
            s1_valid_next = 1'b1;
        end
        else if (go)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
        out_valid_next = go ? emit : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_OPCODE;
            cur_op_reg    <= 8'd0;
            exp_len_reg   <= 8'd0;
            seen_reg      <= 8'd0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            cur_op_reg    <= cur_op_next;
            exp_len_reg   <= exp_len_next;
            seen_reg      <= seen_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_byte_reg <= byte_in;
        end
        if (go && emit)
        begin
            o_op_reg   <= o_op_next;
            o_byte_reg <= o_byte_next;
            o_pv_reg   <= o_pv_next;
            o_idx_reg  <= o_idx_next;
            o_len_reg  <= o_len_next;
            o_last_reg <= o_last_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign opcode        = o_op_reg;
    assign payload_byte  = o_byte_reg;
    assign payload_valid = o_pv_reg;
    assign byte_index    = o_idx_reg;
    assign packet_length = o_len_reg;
    assign last          = o_last_reg;

    a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !o_pv_reg |-> o_last_reg)
        else $error("empty packet result not marked last");

    a_index_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && o_pv_reg |-> o_idx_reg < o_len_reg)
        else $error("payload index beyond packet length");

    a_payload_len: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_PAYLOAD |-> exp_len_reg != 8'd0 && seen_reg < exp_len_reg)
        else $error("payload phase with inconsistent length state");

    a_hold_stage: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !go |=> s1_valid_reg && $stable(s1_byte_reg))
        else $error("held byte lost while output stalled");

endmodule

>>> hw/rtl/opcode_length_packet_deframer_core.sv
// Top level of the opcode/length packet deframer.
//
// Input channel (in_valid / in_stall): each word is either a stream byte
// (func = 0, byte_value) or a length table write (func = 1, table_index,
// table_length, table_variable). A word is taken at a clock edge with
// in_valid high and in_stall low.
// Output channel (out_valid / out_stall): one word per payload byte with its
// opcode, byte_index, packet_length and last flag; an empty packet gives a
// single word with payload_valid low and last high. Opcode and length bytes
// of non-empty packets give no output word.
// Throughput is one input word per cycle while in_stall is low. A stream
// byte reads the length table at acceptance and is resolved at the next
// edge at which the output is not stalled; that edge loads the output register.
// Table writes land in the memory at acceptance and give no output word.
// When the receiver stalls, the output register holds its word; the next
// byte then waits in the parser stage and in_stall rises.
// Reset empties both stages, returns to waiting for an opcode and marks
// every table entry as fixed length zero at once; no clearing pass is run.
module opcode_length_packet_deframer_core #(
    parameter int TABLE_ENTRIES = 256
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       func,
    input  logic [7:0] byte_value,
    input  logic [7:0] table_index,
    input  logic [7:0] table_length,
    input  logic       table_variable,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] opcode,
    output logic [7:0] payload_byte,
    output logic       payload_valid,
    output logic [7:0] byte_index,
    output logic [7:0] packet_length,
    output logic       last
);

    logic             accept;
    logic             take;
    logic             wr_en;
    logic             up_stall;
    oldf_pkg::entry_t wr_entry;
    oldf_pkg::entry_t rd_entry;

    assign in_stall = up_stall;
    assign accept   = in_valid && !up_stall;
    assign take     = accept && (func == oldf_pkg::FUNC_STREAM);
    assign wr_en    = accept && (func == oldf_pkg::FUNC_TABLE);

    assign wr_entry.variable = table_variable;
    assign wr_entry.len      = table_length;

    oldf_len_table #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_addr  (table_index),
        .wr_entry (wr_entry),
        .rd_en    (take),
        .rd_addr  (byte_value),
        .rd_entry (rd_entry)
    );

    oldf_parser u_parser (
        .clk           (clk),
        .rst_n         (rst_n),
        .take          (take),
        .byte_in       (byte_value),
        .entry         (rd_entry),
        .out_stall     (out_stall),
        .up_stall      (up_stall),
        .out_valid     (out_valid),
        .opcode        (opcode),
        .payload_byte  (payload_byte),
        .payload_valid (payload_valid),
        .byte_index    (byte_index),
        .packet_length (packet_length),
        .last          (last)
    );

endmodule

>>> verif/opcode_length_packet_deframer_core_test.sv
// Testbench for the opcode/length packet deframer: directed and random streams.
`timescale 1ns / 1ps

module opcode_length_packet_deframer_core_test;

    localparam int TABLE_ENTRIES = 256;
    localparam int RANDOM_WORDS  = 830;
    localparam int POOL_SIZE     = 12;
    localparam int LONG_HOLD     = 200;
    localparam int DRAIN_CYCLES  = 8;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int REPORT_LIMIT  = 10;

    typedef enum logic [1:0] {
        WAIT_OPCODE,
        WAIT_LENGTH,
        IN_PAYLOAD
    } parse_phase_t;

    typedef struct packed {
        logic [7:0] opcode;
        logic [7:0] pbyte;
        logic       pvalid;
        logic [7:0] idx;
        logic [7:0] plen;
        logic       last;
    } deframe_word_t;

    logic       clk;
    logic       rst_n          = 1'b0;
    logic       in_valid       = 1'b0;
    logic       in_stall;
    logic       func           = oldf_pkg::FUNC_STREAM;
    logic [7:0] byte_value     = 8'h00;
    logic [7:0] table_index    = 8'h00;
    logic [7:0] table_length   = 8'h00;
    logic       table_variable = 1'b0;
    logic       out_valid;
    logic       out_stall      = 1'b0;
    logic [7:0] opcode;
    logic [7:0] payload_byte;
    logic       payload_valid;
    logic [7:0] byte_index;
    logic [7:0] packet_length;
    logic       last;

    // Shadow copy of the parser state and the length table.
    parse_phase_t     parse_phase = WAIT_OPCODE;
    logic [7:0]       cur_opcode  = 8'h00;
    logic [7:0]       exp_length  = 8'h00;
    logic [7:0]       bytes_seen  = 8'h00;
    oldf_pkg::entry_t len_table [TABLE_ENTRIES];

    deframe_word_t expected_words [$];
    logic [7:0]    opcode_pool [POOL_SIZE];

    int   words_accepted = 0;
    int   mismatch_count = 0;
    int   cycle_count    = 0;
    int   send_gap_pct   = 0;
    int   recv_stall_pct = 0;
    int   stall_left     = 0;
    logic hold_request   = 1'b0;

    opcode_length_packet_deframer_core #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .func          (func),
        .byte_value    (byte_value),
        .table_index   (table_index),
        .table_length  (table_length),
        .table_variable(table_variable),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .opcode        (opcode),
        .payload_byte  (payload_byte),
        .payload_valid (payload_valid),
        .byte_index    (byte_index),
        .packet_length (packet_length),
        .last          (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Mostly short idle stretches, now and then a long one.
    function automatic int idle_length(int pct);
        if ($urandom_range(0, 99) < pct)
        begin
            if ($urandom_range(0, 9) == 0)
                return $urandom_range(8, 30);
            return $urandom_range(1, 3);
        end
        return 0;
    endfunction

    function automatic logic [7:0] small_length();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return 8'd0;
        if (r < 16)
            return 8'($urandom_range(1, 6));
        return 8'($urandom_range(7, 40));
    endfunction

    function automatic void push_empty_packet();
        expected_words.push_back(deframe_word_t'{cur_opcode, 8'h00, 1'b0, 8'h00, 8'h00,
                                                 1'b1});
        parse_phase = WAIT_OPCODE;
        exp_length  = 8'h00;
        bytes_seen  = 8'h00;
    endfunction

    function automatic void deframe_predict(logic f, logic [7:0] b, logic [7:0] tidx,
                                            logic [7:0] tlen, logic tvar);
        oldf_pkg::entry_t ent;
        logic             is_last;
        if (f == oldf_pkg::FUNC_TABLE)
        begin
            if (int'(tidx) < TABLE_ENTRIES)
                len_table[tidx] = '{variable: tvar, len: tlen};
            return;
        end
        case (parse_phase)
            WAIT_LENGTH:
            begin
                if (b == 8'h00)
                    push_empty_packet();
                else
                begin
                    exp_length  = b;
                    bytes_seen  = 8'h00;
                    parse_phase = IN_PAYLOAD;
                end
            end
            IN_PAYLOAD:
            begin
                is_last = (int'(bytes_seen) + 1 >= int'(exp_length));
                expected_words.push_back(deframe_word_t'{cur_opcode, b, 1'b1, bytes_seen,
                                                         exp_length, is_last});
                if (is_last)
                begin
                    parse_phase = WAIT_OPCODE;
                    bytes_seen  = 8'h00;
                end
                else
                    bytes_seen = bytes_seen + 8'd1;
            end
            default:
            begin
                cur_opcode = b;
                ent = (int'(b) < TABLE_ENTRIES) ? len_table[b] : '0;
                if (ent.variable)
                begin
                    parse_phase = WAIT_LENGTH;
                    exp_length  = 8'h00;
                    bytes_seen  = 8'h00;
                end
                else if (ent.len == 8'h00)
                    push_empty_packet();
                else
                begin
                    exp_length  = ent.len;
                    bytes_seen  = 8'h00;
                    parse_phase = IN_PAYLOAD;
                end
            end
        endcase
    endfunction

    // Offers one word, waits until it is taken, then idles for a while.
    task automatic send_word(input logic f, input logic [7:0] b, input logic [7:0] tidx,
                             input logic [7:0] tlen, input logic tvar);
        int gap;
        in_valid       <= 1'b1;
        func           <= f;
        byte_value     <= b;
        table_index    <= tidx;
        table_length   <= tlen;
        table_variable <= tvar;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        deframe_predict(f, b, tidx, tlen, tvar);
        words_accepted++;
        gap = idle_length(send_gap_pct);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_word(oldf_pkg::FUNC_STREAM, b, 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    endtask

    task automatic write_entry(input logic [7:0] tidx, input logic [7:0] tlen,
                               input logic tvar);
        send_word(oldf_pkg::FUNC_TABLE, 8'($urandom_range(0, 255)), tidx, tlen, tvar);
    endtask

    // Receiver: random stall runs, plus one long hold on request.
    always @(posedge clk)
    begin
        int run;
        if (hold_request)
        begin
            hold_request = 1'b0;
            stall_left   = LONG_HOLD;
        end
        if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left--;
        end
        else
        begin
            run = idle_length(recv_stall_pct);
            out_stall  <= (run > 0);
            stall_left = (run > 0) ? run - 1 : 0;
        end
    end

    always @(posedge clk)
    begin
        deframe_word_t exp_w;
        deframe_word_t got_w;
        if (rst_n && out_valid && !out_stall)
        begin
            got_w = '{opcode, payload_byte, payload_valid, byte_index, packet_length, last};
            if (expected_words.size() == 0)
            begin
                if (mismatch_count < REPORT_LIMIT)
                    $display("unexpected output word: op=%02h byte=%02h pv=%0b",
                             got_w.opcode, got_w.pbyte, got_w.pvalid,
                             " idx=%0d len=%0d last=%0b",
                             got_w.idx, got_w.plen, got_w.last);
                mismatch_count++;
            end
            else
            begin
                exp_w = expected_words.pop_front();
                if (got_w.opcode !== exp_w.opcode || got_w.pbyte !== exp_w.pbyte ||
                    got_w.pvalid !== exp_w.pvalid || got_w.idx !== exp_w.idx ||
                    got_w.plen !== exp_w.plen || got_w.last !== exp_w.last)
                begin
                    if (mismatch_count < REPORT_LIMIT)
                    begin
                        $display("mismatch: expected op=%02h byte=%02h pv=%0b",
                                 exp_w.opcode, exp_w.pbyte, exp_w.pvalid,
                                 " idx=%0d len=%0d last=%0b",
                                 exp_w.idx, exp_w.plen, exp_w.last);
                        $display("          got      op=%02h byte=%02h pv=%0b",
                                 got_w.opcode, got_w.pbyte, got_w.pvalid,
                                 " idx=%0d len=%0d last=%0b",
                                 got_w.idx, got_w.plen, got_w.last);
                    end
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("simulation failed");
        $finish;
    end

    task automatic test_directed_packets();
        send_gap_pct   = 20;
        recv_stall_pct = 20;
        write_entry(8'h01, 8'd1, 1'b0);
        write_entry(8'hFF, 8'd3, 1'b0);
        // The stored length is ignored for a variable entry.
        write_entry(8'h80, 8'hFF, 1'b1);
        send_byte(8'h00);
        send_byte(8'h7E);
        send_byte(8'h01);
        send_byte(8'hFF);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'h55);
        send_byte(8'hAA);
        send_byte(8'h80);
        send_byte(8'h00);
        send_byte(8'h80);
        send_byte(8'h02);
        send_byte(8'h11);
        send_byte(8'hEE);
        // Rewriting the entry mid-packet must not change the length already latched.
        send_byte(8'hFF);
        send_byte(8'h12);
        write_entry(8'hFF, 8'd1, 1'b0);
        send_byte(8'h34);
        send_byte(8'h56);
    endtask

    task automatic random_packet();
        if ($urandom_range(0, 9) == 0)
        begin
            if ($urandom_range(0, 1) == 0)
                send_byte(8'($urandom_range(0, 255)));
            else
                write_entry(8'($urandom_range(0, 255)), small_length(),
                            1'($urandom_range(0, 1)));
        end
        else if ($urandom_range(0, 9) < 7)
            send_byte(opcode_pool[$urandom_range(0, POOL_SIZE - 1)]);
        else
            send_byte(8'($urandom_range(0, 255)));
        while (parse_phase != WAIT_OPCODE)
        begin
            if (parse_phase == WAIT_LENGTH)
                send_byte(($urandom_range(0, 9) == 0) ? 8'h00 : small_length());
            else if ($urandom_range(0, 19) == 0)
                write_entry(8'($urandom_range(0, 255)), small_length(),
                            1'($urandom_range(0, 1)));
            else
                send_byte(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic run_segment(input int gap_pct, input int stall_pct);
        int stop_at;
        send_gap_pct   = gap_pct;
        recv_stall_pct = stall_pct;
        stop_at        = words_accepted + RANDOM_WORDS / 5;
        while (words_accepted < stop_at)
            random_packet();
    endtask

    task automatic test_random_stream();
        send_gap_pct   = 10;
        recv_stall_pct = 10;
        for (int k = 0; k < POOL_SIZE; k++)
        begin
            opcode_pool[k] = 8'($urandom_range(0, 255));
            write_entry(opcode_pool[k], small_length(), ($urandom_range(0, 3) == 0));
        end
        run_segment(0, 0);
        run_segment(25, 25);
        run_segment(5, 60);
        run_segment(60, 5);
        run_segment(15, 15);
    endtask

    // Largest packet: length byte 255 gives indexes up to 254.
    task automatic test_longest_packet();
        send_gap_pct   = 10;
        recv_stall_pct = 10;
        write_entry(8'h80, 8'h00, 1'b1);
        send_byte(8'h80);
        send_byte(8'hFF);
        repeat (255) send_byte(8'($urandom_range(0, 255)));
    endtask

    // The receiver holds off while words keep coming, so the block must stall its input.
    task automatic test_input_backpressure();
        send_gap_pct   = 0;
        recv_stall_pct = 0;
        write_entry(8'h42, 8'd6, 1'b0);
        hold_request = 1'b1;
        repeat (4)
        begin
            send_byte(8'h42);
            repeat (6) send_byte(8'($urandom_range(0, 255)));
        end
    endtask

    initial
    begin
        foreach (len_table[k])
            len_table[k] = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        test_directed_packets();
        test_random_stream();
        test_longest_packet();
        test_input_backpressure();
        in_valid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
